/* hw/rtl/touch_wheel_gesture_decoder_assert.svh */
// Assertion macros shared by the checker files of the touch wheel gesture decoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TOUCH_WHEEL_GESTURE_DECODER_ASSERT_SVH
`define TOUCH_WHEEL_GESTURE_DECODER_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define TWGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define TWGD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/twgd_pkg.sv */
// Package for the touch wheel gesture decoder: config and result types,
// register indexes, reset values and code constants. No dependencies.
`timescale 1ns / 1ps

package twgd_pkg;

  localparam int WHEEL_PADS_DEF = 8;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int SWIPE_PADS     = 4;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_KEEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS   = 2'd2;

  localparam logic [CFG_W-1:0] PAD_KEEP_RST  = 16'd500;
  localparam logic [CFG_W-1:0] SWIPE_WIN_RST = 16'd300;
  localparam logic [CFG_W-1:0] HOLD_MS_RST   = 16'd1000;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [1:0] STEP_BACK = 2'sb11;

  localparam logic [2:0] DIR_NONE = 3'd0;

  typedef struct packed {
    logic [CFG_W-1:0] pad_keep_ms;
    logic [CFG_W-1:0] swipe_win_ms;
    logic [CFG_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] wheel_step;
    logic [2:0]        swipe_dir;
    logic              button_held;
  } res_t;

endpackage

/* hw/rtl/twgd_eval.sv */
// Combinational evaluation of one pad poll: button hold, swipe and wheel step,
// plus the next decoder state. Depends on twgd_pkg.
`timescale 1ns / 1ps

module twgd_eval import twgd_pkg::*; #(
  parameter int WHEEL_PADS = WHEEL_PADS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  localparam int PAD_W = WHEEL_PADS + 1 + SWIPE_PADS,
  localparam int PW    = $clog2(WHEEL_PADS + 1)
) (
  input  logic [PAD_W-1:0]      pad_bits,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  cfg_t                  cfg,
  input  logic                  btn_down,
  input  logic [TIME_WIDTH-1:0] press_time,
  input  logic [PW-1:0]         last_pad,
  input  logic [TIME_WIDTH-1:0] mark_time,
  output res_t                  res,
  output logic                  btn_down_nxt,
  output logic [TIME_WIDTH-1:0] press_time_nxt,
  output logic [PW-1:0]         last_pad_nxt,
  output logic [TIME_WIDTH-1:0] mark_time_nxt
);

  localparam int          SWIPE_BASE = WHEEL_PADS + 1;
  localparam logic [PW:0] N_C        = (PW + 1)'(WHEEL_PADS);

  logic [TIME_WIDTH-1:0] held_age;
  logic [TIME_WIDTH-1:0] swipe_age;
  logic [TIME_WIDTH-1:0] wheel_age;
  logic [PW-1:0]         cur_pad;
  logic [PW-1:0]         last_eff;
  logic [PW:0]           ring_d;
  logic                  fwd;
  logic                  back;
  logic [2:0]            swipe_idx;
  logic                  held_flag;
  logic [2:0]            swipe_code;
  logic signed [1:0]     wheel_code;

  assign res = '{wheel_step: wheel_code, swipe_dir: swipe_code, button_held: held_flag};

  // Button hold.
  always_comb begin
    held_age       = now_ms - press_time;
    press_time_nxt = press_time;
    held_flag      = 1'b0;
    btn_down_nxt   = pad_bits[0];
    if (pad_bits[0]) begin
      if (!btn_down) begin
        press_time_nxt = now_ms;
      end else if (held_age >= TIME_WIDTH'(cfg.hold_ms)) begin
        held_flag = 1'b1;
      end
    end
  end

  // Swipe: window measured from the press time as updated by this poll.
  always_comb begin
    swipe_age = now_ms - press_time_nxt;
    swipe_idx = DIR_NONE;
    for (int i = SWIPE_PADS - 1; i >= 0; i--) begin
      if (pad_bits[SWIPE_BASE + i]) begin
        swipe_idx = 3'(i + 1);
      end
    end
    swipe_code = (swipe_age < TIME_WIDTH'(cfg.swipe_win_ms)) ? swipe_idx : DIR_NONE;
  end

  // Wheel: lowest pressed ring pad against the remembered one.
  always_comb begin
    cur_pad = '0;
    for (int i = WHEEL_PADS - 1; i >= 0; i--) begin
      if (pad_bits[1 + i]) begin
        cur_pad = PW'(i + 1);
      end
    end
    wheel_age = now_ms - mark_time;
    last_eff  = (wheel_age > TIME_WIDTH'(cfg.pad_keep_ms)) ? '0 : last_pad;

    // Ring distance from the current pad forward to the remembered pad.
    if (last_eff >= cur_pad) begin
      ring_d = {1'b0, last_eff} - {1'b0, cur_pad};
    end else begin
      ring_d = {1'b0, last_eff} + N_C - {1'b0, cur_pad};
    end
    fwd  = (last_eff != '0) && ((ring_d == N_C - 1'b1) || (ring_d == N_C - 2'd2));
    back = (last_eff != '0) && ((ring_d == (PW + 1)'(1)) || (ring_d == (PW + 1)'(2)));

    wheel_code    = STEP_NONE;
    last_pad_nxt  = last_eff;
    mark_time_nxt = mark_time;
    if (cur_pad != '0) begin
      if (fwd) begin
        wheel_code = STEP_FWD;
      end else if (back) begin
        wheel_code = STEP_BACK;
      end else if (cur_pad != last_eff) begin
        last_pad_nxt  = cur_pad;
        mark_time_nxt = now_ms;
      end
    end
  end

endmodule

/* hw/rtl/touch_wheel_gesture_decoder.sv */
// Top level of the touch wheel gesture decoder: input register, evaluation
// stage, decoder state and result register. Depends on twgd_pkg and twgd_eval.
`timescale 1ns / 1ps

// The decoder takes one pad poll per clock cycle and returns one result per
// poll: the poll is captured in an input register when the request is
// accepted, evaluated combinationally against the button and wheel state,
// and loaded into the output register, where the result is held until it is
// taken. The state update loop (press time, remembered wheel pad and its
// time stamp) allows one poll per cycle while the result side does not stall.
// When the result side stalls, in_ready stays high only while the input
// register is empty, so it can take one more request before in_ready drops.
// Configuration writes take effect at once and are meant for idle time.
module touch_wheel_gesture_decoder import twgd_pkg::*; #(
  parameter int WHEEL_PADS = WHEEL_PADS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  localparam int PAD_W = WHEEL_PADS + 1 + SWIPE_PADS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PAD_W-1:0]        in_pad_bits,
  input  logic [TIME_WIDTH-1:0]   in_now_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [1:0]       out_wheel_step,
  output logic [2:0]              out_swipe_dir,
  output logic                    out_button_held,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int PW = $clog2(WHEEL_PADS + 1);

  cfg_t                  cfg_r;
  logic                  in_valid_r;
  logic [PAD_W-1:0]      in_pads_r;
  logic [TIME_WIDTH-1:0] in_now_r;
  logic                  out_valid_r;
  res_t                  out_res_r;
  logic                  btn_down_r;
  logic [TIME_WIDTH-1:0] press_time_r;
  logic [PW-1:0]         last_pad_r;
  logic [TIME_WIDTH-1:0] mark_time_r;

  res_t                  res_nxt;
  logic                  btn_down_nxt;
  logic [TIME_WIDTH-1:0] press_time_nxt;
  logic [PW-1:0]         last_pad_nxt;
  logic [TIME_WIDTH-1:0] mark_time_nxt;
  logic                  advance;
  logic                  fire;

  twgd_eval #(
    .WHEEL_PADS (WHEEL_PADS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .pad_bits       (in_pads_r),
    .now_ms         (in_now_r),
    .cfg            (cfg_r),
    .btn_down       (btn_down_r),
    .press_time     (press_time_r),
    .last_pad       (last_pad_r),
    .mark_time      (mark_time_r),
    .res            (res_nxt),
    .btn_down_nxt   (btn_down_nxt),
    .press_time_nxt (press_time_nxt),
    .last_pad_nxt   (last_pad_nxt),
    .mark_time_nxt  (mark_time_nxt)
  );

  // The result register frees up when it is empty or being taken.
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pad_keep_ms  <= PAD_KEEP_RST;
      cfg_r.swipe_win_ms <= SWIPE_WIN_RST;
      cfg_r.hold_ms      <= HOLD_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PAD_KEEP:  cfg_r.pad_keep_ms  <= cfg_data;
        REG_SWIPE_WIN: cfg_r.swipe_win_ms <= cfg_data;
        REG_HOLD_MS:   cfg_r.hold_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      btn_down_r   <= 1'b0;
      press_time_r <= '0;
      last_pad_r   <= '0;
      mark_time_r  <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        btn_down_r   <= btn_down_nxt;
        press_time_r <= press_time_nxt;
        last_pad_r   <= last_pad_nxt;
        mark_time_r  <= mark_time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pads_r <= in_pad_bits;
      in_now_r  <= in_now_ms;
    end
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_step  = out_res_r.wheel_step;
  assign out_swipe_dir   = out_res_r.swipe_dir;
  assign out_button_held = out_res_r.button_held;

endmodule

/* hw/rtl/twgd_checker.sv */
// Port-level checks for the touch wheel gesture decoder, bound to the top level.
// Depends on touch_wheel_gesture_decoder_assert.svh and twgd_pkg.
`timescale 1ns / 1ps
`include "touch_wheel_gesture_decoder_assert.svh"

module twgd_checker import twgd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] out_wheel_step,
  input logic [2:0]        out_swipe_dir,
  input logic              out_button_held
);

  // A result that waits keeps its value.
  `TWGD_ASSERT(a_out_hold, out_valid && !out_ready |=> $stable(out_wheel_step) && $stable(out_swipe_dir) && $stable(out_button_held), "stalled result changed")

  // An empty result register always leaves room for a new request.
  `TWGD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // A shown result never carries the unused step code or a direction code above 4.
  `TWGD_ASSERT(a_codes_legal, out_valid |-> (out_wheel_step != 2'sb10) && (out_swipe_dir <= 3'd4), "illegal result code")

  // No result is offered right after reset.
  `TWGD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind touch_wheel_gesture_decoder twgd_checker u_twgd_checker (.*);
